// File: rtl/scd_pkg.sv
// Package for the serial command deframer: phase encoding, status codes
// and the result record passed between the frame engine and the output stage.
// No dependencies.
package scd_pkg;

    typedef enum logic [2:0] {
        PH_WAIT = 3'd0,
        PH_LEN  = 3'd1,
        PH_SUB  = 3'd2,
        PH_ORD  = 3'd3,
        PH_PAY  = 3'd4,
        PH_CHK  = 3'd5,
        PH_TAIL = 3'd6,
        PH_DROP = 3'd7
    } phase_t;

    localparam logic [7:0] HEAD_BYTE = 8'hFE;
    localparam logic [7:0] TAIL_BYTE = 8'hFF;
    localparam logic [8:0] SUM_MOD   = 9'd254;

    localparam logic [1:0] ST_GOOD     = 2'd0;
    localparam logic [1:0] ST_BAD_TAIL = 2'd1;
    localparam logic [1:0] ST_BAD_SUM  = 2'd2;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [7:0] command_code;
        logic [7:0] sub_code;
        logic [7:0] payload_length;
        logic [1:0] frame_status;
        logic [7:0] computed_sum;
        logic       last;
    } result_t;

endpackage

// File: rtl/scd_in_reg.sv
// Input register of the serial command deframer: captures one received byte
// and its chunk-end flag. Depends on nothing else.
module scd_in_reg
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       chunk_end,
    input  logic       take,
    output logic       held_valid,
    output logic [7:0] held_byte,
    output logic       held_end
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       end_reg;

    // The register can load whenever it is empty or being emptied this cycle.
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
            end_reg  <= chunk_end;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_end   = end_reg;

endmodule

// File: rtl/scd_frame_fsm.sv
// Frame recognition engine: phase machine, counters and the modulo-254 sum.
// Uses scd_pkg for the phase type, status codes and the result record.
module scd_frame_fsm
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    input  logic             chunk_end,
    output logic             res_valid,
    output scd_pkg::result_t res
);

    scd_pkg::phase_t phase_reg, phase_next, phase_sw;
    logic [7:0] frame_len_reg,    frame_len_next;
    logic [7:0] byte_count_reg,   byte_count_next;
    logic [7:0] running_sum_reg,  running_sum_next;
    logic [7:0] held_command_reg, held_command_next;
    logic [7:0] held_sub_reg,     held_sub_next;
    logic       sum_ok_reg,       sum_ok_next;
    logic       first_tail_ok_reg, first_tail_ok_next;

    logic [8:0] sum_raw;
    logic [7:0] sum_mod;
    logic [7:0] count_inc;

    // Sum of a value below 254 and a byte stays below 509, so at most two
    // subtractions of the modulus are ever needed.
    always_comb
    begin
        sum_raw = {1'b0, running_sum_reg} + {1'b0, rx_byte};
        if (sum_raw >= (scd_pkg::SUM_MOD << 1))
        begin
            sum_mod = 8'(sum_raw - (scd_pkg::SUM_MOD << 1));
        end
        else if (sum_raw >= scd_pkg::SUM_MOD)
        begin
            sum_mod = 8'(sum_raw - scd_pkg::SUM_MOD);
        end
        else
        begin
            sum_mod = sum_raw[7:0];
        end
    end

    assign count_inc = byte_count_reg + 8'd1;

    always_comb
    begin
        phase_sw           = phase_reg;
        frame_len_next     = frame_len_reg;
        byte_count_next    = byte_count_reg;
        running_sum_next   = running_sum_reg;
        held_command_next  = held_command_reg;
        held_sub_next      = held_sub_reg;
        sum_ok_next        = sum_ok_reg;
        first_tail_ok_next = first_tail_ok_reg;
        res_valid          = 1'b0;
        res.kind           = scd_pkg::KIND_PAYLOAD;
        res.payload_byte   = 8'd0;
        res.frame_status   = scd_pkg::ST_GOOD;
        res.last           = 1'b0;

        case (phase_reg)
            scd_pkg::PH_WAIT:
            begin
                if (rx_byte == scd_pkg::HEAD_BYTE)
                begin
                    phase_sw           = scd_pkg::PH_LEN;
                    frame_len_next     = 8'd0;
                    byte_count_next    = 8'd0;
                    running_sum_next   = 8'd0;
                    held_command_next  = 8'd0;
                    held_sub_next      = 8'd0;
                    sum_ok_next        = 1'b0;
                    first_tail_ok_next = 1'b0;
                end
                else
                begin
                    phase_sw = scd_pkg::PH_DROP;
                end
            end
            scd_pkg::PH_LEN:
            begin
                frame_len_next = rx_byte;
                phase_sw       = scd_pkg::PH_SUB;
            end
            scd_pkg::PH_SUB:
            begin
                held_sub_next    = rx_byte;
                running_sum_next = sum_mod;
                phase_sw         = scd_pkg::PH_ORD;
            end
            scd_pkg::PH_ORD:
            begin
                held_command_next = rx_byte;
                running_sum_next  = sum_mod;
                byte_count_next   = 8'd0;
                phase_sw = (frame_len_reg == 8'd0) ? scd_pkg::PH_CHK : scd_pkg::PH_PAY;
            end
            scd_pkg::PH_PAY:
            begin
                running_sum_next = sum_mod;
                byte_count_next  = count_inc;
                res_valid        = 1'b1;
                res.payload_byte = rx_byte;
                if (count_inc >= frame_len_reg)
                begin
                    phase_sw = scd_pkg::PH_CHK;
                end
            end
            scd_pkg::PH_CHK:
            begin
                sum_ok_next     = (rx_byte == running_sum_reg);
                byte_count_next = 8'd0;
                phase_sw        = scd_pkg::PH_TAIL;
            end
            scd_pkg::PH_TAIL:
            begin
                if (byte_count_reg == 8'd0)
                begin
                    first_tail_ok_next = (rx_byte == scd_pkg::TAIL_BYTE);
                    byte_count_next    = 8'd1;
                end
                else
                begin
                    res_valid = 1'b1;
                    res.kind  = scd_pkg::KIND_STATUS;
                    res.last  = 1'b1;
                    // A bad trailer outranks a checksum mismatch.
                    if (!(first_tail_ok_reg && rx_byte == scd_pkg::TAIL_BYTE))
                    begin
                        res.frame_status = scd_pkg::ST_BAD_TAIL;
                    end
                    else if (!sum_ok_reg)
                    begin
                        res.frame_status = scd_pkg::ST_BAD_SUM;
                    end
                    else
                    begin
                        res.frame_status = scd_pkg::ST_GOOD;
                    end
                    byte_count_next = 8'd0;
                    phase_sw        = scd_pkg::PH_DROP;
                end
            end
            default:
            begin
                phase_sw = phase_reg;
            end
        endcase

        // The end of a chunk ends any dropping, including right after a frame.
        phase_next = (chunk_end && phase_sw == scd_pkg::PH_DROP) ? scd_pkg::PH_WAIT : phase_sw;

        res.command_code   = held_command_next;
        res.sub_code       = held_sub_next;
        res.payload_length = frame_len_next;
        res.computed_sum   = running_sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= scd_pkg::PH_WAIT;
            frame_len_reg     <= 8'd0;
            byte_count_reg    <= 8'd0;
            running_sum_reg   <= 8'd0;
            held_command_reg  <= 8'd0;
            held_sub_reg      <= 8'd0;
            sum_ok_reg        <= 1'b0;
            first_tail_ok_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            frame_len_reg     <= frame_len_next;
            byte_count_reg    <= byte_count_next;
            running_sum_reg   <= running_sum_next;
            held_command_reg  <= held_command_next;
            held_sub_reg      <= held_sub_next;
            sum_ok_reg        <= sum_ok_next;
            first_tail_ok_reg <= first_tail_ok_next;
        end
    end

endmodule

// File: rtl/scd_out_reg.sv
// Result register of the serial command deframer: holds one result record
// until the consumer takes it. Uses scd_pkg for the result record.
module scd_out_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  scd_pkg::result_t load_res,
    output logic             free,
    output logic             out_valid,
    input  logic             out_ready,
    output scd_pkg::result_t res
);

    logic             valid_reg;
    logic             valid_next;
    scd_pkg::result_t res_reg;

    assign free       = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

    assign out_valid = valid_reg;
    assign res       = res_reg;

endmodule

// File: rtl/serial_command_deframer_unit.sv
// Top level of the serial command deframer: input register, frame engine
// and result register. Uses scd_pkg, scd_in_reg, scd_frame_fsm, scd_out_reg.
//
//  Channel   Handshake            Payload
//  -------   ------------------   -------------------------------------------
//  input     in_valid / in_ready  rx_byte, chunk_end
//  output    out_valid/out_ready  kind, payload_byte, command_code, sub_code,
//                                 payload_length, frame_status, computed_sum,
//                                 last
//
// Each accepted item is held in the input register, where the frame engine
// works on it, and its result (if any) is written to the result register
// when the engine steps on it. One item per cycle is sustained while the
// consumer does not stall. The single-cycle throughput is set by the phase,
// counter and modulo-254 sum update, all of which fit between the two
// registers. Reset is asynchronous and active low; it clears both valid
// flags and returns the engine to waiting for a header byte. When the
// consumer stalls, the engine stops on the held item and the input side
// keeps taking items only until the input register is full.
module serial_command_deframer_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       chunk_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       kind,
    output logic [7:0] payload_byte,
    output logic [7:0] command_code,
    output logic [7:0] sub_code,
    output logic [7:0] payload_length,
    output logic [1:0] frame_status,
    output logic [7:0] computed_sum,
    output logic       last
);

    logic             held_valid;
    logic [7:0]       held_byte;
    logic             held_end;
    logic             step;
    logic             out_free;
    logic             res_valid;
    scd_pkg::result_t fsm_res;
    scd_pkg::result_t out_res;

    // The held item is processed once the result register can take whatever
    // it produces; an item that yields no result still waits for that, which
    // keeps the handshake simple without costing throughput in steady flow.
    assign step = held_valid && out_free;

    scd_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .chunk_end  (chunk_end),
        .take       (step),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .held_end   (held_end)
    );

    scd_frame_fsm u_frame_fsm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (held_byte),
        .chunk_end (held_end),
        .res_valid (res_valid),
        .res       (fsm_res)
    );

    scd_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_valid),
        .load_res  (fsm_res),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (out_res)
    );

    assign kind           = out_res.kind;
    assign payload_byte   = out_res.payload_byte;
    assign command_code   = out_res.command_code;
    assign sub_code       = out_res.sub_code;
    assign payload_length = out_res.payload_length;
    assign frame_status   = out_res.frame_status;
    assign computed_sum   = out_res.computed_sum;
    assign last           = out_res.last;

endmodule
